// File: rtl/mdfm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mdfm_pkg
// shared types, constants and helper functions of the motor drive fault
// monitor
// ---------------------------------------------------------------------------
package mdfm_pkg;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int SCALE_W = 17;
	localparam int RAMP_W  = 25;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 17'd65536;
	localparam logic signed [RAMP_W-1:0] RAMP_SPAN = 25'sd640;
	// ceil(2^21 / 5), exact for numerators below 2^19
	localparam logic [28:0] RAMP_RECIP = 29'd419431;

	localparam logic [14:0] CURRENT_LIMIT_RST       = 15'd2560;
	localparam logic [14:0] SHORT_CURRENT_LIMIT_RST = 15'd3840;
	localparam logic [14:0] BUS_VOLTAGE_HIGH_RST    = 15'd4800;
	localparam logic [14:0] BUS_VOLTAGE_LOW_RST     = 15'd1152;
	localparam logic [15:0] DRIVE_TEMP_LIMIT_RST    = 16'd4480;
	localparam logic [15:0] MOTOR_TEMP_LIMIT_RST    = 16'd4480;
	localparam logic [22:0] VELOCITY_LIMIT_RST      = 23'd0;

	localparam logic [1:0] EN_SOFT = 2'b00;
	localparam logic [1:0] EN_HARD = 2'b11;

	typedef enum logic [2:0] {
		FAULT_NONE        = 3'd0,
		FAULT_SHORT       = 3'd1,
		FAULT_UNDERVOLT   = 3'd2,
		FAULT_OVERTEMP    = 3'd3,
		FAULT_OVERCURRENT = 3'd4,
		FAULT_OVERVOLT    = 3'd5
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CURRENT_LIMIT       = 3'd0,
		REG_SHORT_CURRENT_LIMIT = 3'd1,
		REG_BUS_VOLTAGE_HIGH    = 3'd2,
		REG_BUS_VOLTAGE_LOW     = 3'd3,
		REG_DRIVE_TEMP_LIMIT    = 3'd4,
		REG_MOTOR_TEMP_LIMIT    = 3'd5,
		REG_VELOCITY_LIMIT      = 3'd6
	} reg_idx_t;

	function automatic logic [16:0] abs16(input logic [15:0] x);
		logic signed [16:0] e;
		e = {x[15], x};
		return e[16] ? 17'(-e) : 17'(e);
	endfunction

	function automatic logic [23:0] abs24(input logic [23:0] x);
		logic signed [24:0] e;
		e = {x[23], x};
		return e[24] ? 24'(-e) : 24'(e);
	endfunction

	// clamped ramp over 640 units: 0 at or past the limit, 1.0 at 640 or more units below
	function automatic logic [SCALE_W-1:0] ramp(input logic signed [RAMP_W-1:0] r);
		logic [28:0] prod;
		prod = 29'(r[9:0]) * RAMP_RECIP;
		if (r <= 0) begin
			return '0;
		end else if (r >= RAMP_SPAN) begin
			return SCALE_ONE;
		end else begin
			return prod[28:12];
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/motor_drive_fault_monitor.sv
`default_nettype none
// ---------------------------------------------------------------------------
// motor_drive_fault_monitor
// Per-tick fault checks on bus voltage, phase currents and drive temperature
// with a latched fault code, plus a derated current limit.
//
// Items come in on the s_axis channel (one sample set per item) and each one
// gives exactly one result item on m_axis. Limits are written through the cfg
// channel, which is always ready; write it only while no item is in flight.
// m_axis_tvalid follows an accepted input item through three register stages:
// an input register, a stage for the fault checks and the three ramps, and
// the output stage holding the minimum ramp and its product with the current
// limit.
// Throughput is one item per cycle while m_axis_tready stays high; the ramp
// multipliers and the derating multiplier each sit in their own stage.
// When m_axis_tready is low the output register holds its item and the
// earlier stages keep filling, so s_axis_tready drops only once all three
// stages are full. Reset empties the pipeline, clears the latched fault and
// loads the default limits.
// ---------------------------------------------------------------------------
module motor_drive_fault_monitor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// enable_in, bus_voltage, current_u, current_v, current_w, drive_temp,
	// motor_temp, velocity, zero pad
	input  wire logic [mdfm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// enable_out, fault_code, derate_scale, derated_current_limit, zero pad
	output logic [mdfm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mdfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mdfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mdfm_pkg::*;

	logic [14:0] current_limit_q;
	logic [14:0] short_current_limit_q;
	logic [14:0] bus_voltage_high_q;
	logic [14:0] bus_voltage_low_q;
	logic [15:0] drive_temp_limit_q;
	logic [15:0] motor_temp_limit_q;
	logic [22:0] velocity_limit_q;
	fault_t      fault_q;

	logic        valid_s1, valid_s2, valid_s3;
	logic        adv1, adv2, adv3;

	logic        enable_s1;
	logic [15:0] bus_voltage_s1;
	logic [15:0] current_u_s1, current_v_s1, current_w_s1;
	logic [15:0] drive_temp_s1, motor_temp_s1;
	logic [23:0] velocity_s1;

	logic [1:0]         en_out_s2;
	fault_t             fault_s2;
	logic [SCALE_W-1:0] ramp_dt_s2, ramp_mt_s2, ramp_vel_s2;

	logic [1:0]         en_out_s3;
	fault_t             fault_s3;
	logic [SCALE_W-1:0] scale_s3;
	logic [14:0]        derated_s3;

	logic [16:0]        abs_u, abs_v, abs_w, cur_max;
	logic [20:0]        cur_max_x10;
	logic [18:0]        limit_x11;
	logic [23:0]        vel_abs;
	logic [1:0]         en_out_nxt;
	fault_t             fault_nxt;
	logic signed [RAMP_W-1:0] r_dt, r_mt, r_vel;
	logic [SCALE_W-1:0] scale_min;
	logic [31:0]        derate_prod;

	// handshakes
	assign adv3          = !valid_s3 || m_axis_tready;
	assign adv2          = !valid_s2 || adv3;
	assign adv1          = !valid_s1 || adv2;
	assign s_axis_tready = adv1;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q       <= CURRENT_LIMIT_RST;
			short_current_limit_q <= SHORT_CURRENT_LIMIT_RST;
			bus_voltage_high_q    <= BUS_VOLTAGE_HIGH_RST;
			bus_voltage_low_q     <= BUS_VOLTAGE_LOW_RST;
			drive_temp_limit_q    <= DRIVE_TEMP_LIMIT_RST;
			motor_temp_limit_q    <= MOTOR_TEMP_LIMIT_RST;
			velocity_limit_q      <= VELOCITY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CURRENT_LIMIT:       current_limit_q       <= cfg_data[14:0];
				REG_SHORT_CURRENT_LIMIT: short_current_limit_q <= cfg_data[14:0];
				REG_BUS_VOLTAGE_HIGH:    bus_voltage_high_q    <= cfg_data[14:0];
				REG_BUS_VOLTAGE_LOW:     bus_voltage_low_q     <= cfg_data[14:0];
				REG_DRIVE_TEMP_LIMIT:    drive_temp_limit_q    <= cfg_data[15:0];
				REG_MOTOR_TEMP_LIMIT:    motor_temp_limit_q    <= cfg_data[15:0];
				REG_VELOCITY_LIMIT:      velocity_limit_q      <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// pipeline control and latched fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fault_q  <= FAULT_NONE;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (valid_s1 && adv2) begin
				fault_q <= fault_nxt;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			enable_s1      <= s_axis_tdata[0];
			bus_voltage_s1 <= s_axis_tdata[16:1];
			current_u_s1   <= s_axis_tdata[32:17];
			current_v_s1   <= s_axis_tdata[48:33];
			current_w_s1   <= s_axis_tdata[64:49];
			drive_temp_s1  <= s_axis_tdata[80:65];
			motor_temp_s1  <= s_axis_tdata[96:81];
			velocity_s1    <= s_axis_tdata[120:97];
		end
	end

	// fault checks, later checks override earlier ones
	always_comb begin
		abs_u   = abs16(current_u_s1);
		abs_v   = abs16(current_v_s1);
		abs_w   = abs16(current_w_s1);
		cur_max = abs_u;
		if (abs_v > cur_max) begin
			cur_max = abs_v;
		end
		if (abs_w > cur_max) begin
			cur_max = abs_w;
		end
		cur_max_x10 = (21'(cur_max) << 3) + (21'(cur_max) << 1);
		limit_x11   = (19'(current_limit_q) << 3) + (19'(current_limit_q) << 1)
			+ 19'(current_limit_q);

		fault_nxt  = enable_s1 ? fault_q : FAULT_NONE;
		en_out_nxt = {1'b0, enable_s1};
		if (cur_max > {2'b00, short_current_limit_q}) begin
			fault_nxt  = FAULT_SHORT;
			en_out_nxt = EN_SOFT;
		end
		if ($signed({bus_voltage_s1[15], bus_voltage_s1})
				< $signed({2'b00, bus_voltage_low_q})) begin
			fault_nxt  = FAULT_UNDERVOLT;
			en_out_nxt = EN_SOFT;
		end
		if ($signed(drive_temp_s1) > $signed(drive_temp_limit_q)) begin
			fault_nxt  = FAULT_OVERTEMP;
			en_out_nxt = EN_SOFT;
		end
		if (cur_max_x10 > 21'(limit_x11)) begin
			fault_nxt  = FAULT_OVERCURRENT;
			en_out_nxt = EN_HARD;
		end
		if ($signed({bus_voltage_s1[15], bus_voltage_s1})
				> $signed({2'b00, bus_voltage_high_q})) begin
			fault_nxt  = FAULT_OVERVOLT;
			en_out_nxt = EN_HARD;
		end
	end

	// ramp distances to each limit
	always_comb begin
		vel_abs = abs24(velocity_s1);
		r_dt    = $signed({{9{drive_temp_limit_q[15]}}, drive_temp_limit_q})
			- $signed({{9{drive_temp_s1[15]}}, drive_temp_s1});
		r_mt    = $signed({{9{motor_temp_limit_q[15]}}, motor_temp_limit_q})
			- $signed({{9{motor_temp_s1[15]}}, motor_temp_s1});
		r_vel   = $signed({2'b00, velocity_limit_q}) - $signed({1'b0, vel_abs});
	end

	// stage 2: fault result and ramps
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			en_out_s2   <= en_out_nxt;
			fault_s2    <= fault_nxt;
			ramp_dt_s2  <= ramp(r_dt);
			ramp_mt_s2  <= ramp(r_mt);
			ramp_vel_s2 <= ramp(r_vel);
		end
	end

	// minimum ramp and derated limit
	always_comb begin
		scale_min = ramp_dt_s2;
		if (ramp_mt_s2 < scale_min) begin
			scale_min = ramp_mt_s2;
		end
		if (ramp_vel_s2 < scale_min) begin
			scale_min = ramp_vel_s2;
		end
		derate_prod = 32'(current_limit_q) * 32'(scale_min);
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			en_out_s3  <= en_out_s2;
			fault_s3   <= fault_s2;
			scale_s3   <= scale_min;
			derated_s3 <= derate_prod[30:16];
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {3'b000, derated_s3, scale_s3, fault_s3, en_out_s3};

	// a hard disable only comes from overcurrent or overvoltage
	a_hard_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_out_s3 == EN_HARD)
		|-> (fault_s3 == FAULT_OVERCURRENT || fault_s3 == FAULT_OVERVOLT))
		else $error("hard disable without hard fault code");

	a_derate_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (scale_s3 <= SCALE_ONE && derated_s3 <= current_limit_q))
		else $error("derating out of range");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && adv2) |=> $stable(fault_q))
		else $error("latched fault changed without an item");

	a_fault_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2) |=> (fault_q == fault_s2))
		else $error("latched fault differs from stage result");

endmodule
`default_nettype wire
